// ===== src/xbm_hp_pkg.sv =====
`default_nettype none
// ============================================================================
// xbm_hp_pkg
// Shared types and constants for the XBM header parser.
// ============================================================================
package xbm_hp_pkg;

    localparam int unsigned VAL_W   = 31;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned KPOS_W  = 3;
    localparam int unsigned LINES_W = 3;
    localparam int unsigned CNT_W   = 5;

    localparam logic [VAL_W-1:0] VAL_MAX   = 31'h7FFF_FFFF;
    localparam logic [CNT_W-1:0] MIN_BYTES = 5'd16;

    // parser state carried from word to word
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [KPOS_W-1:0]  kw_pos;
        logic [LINES_W-1:0] lines_done;
        logic               failed;
        logic [VAL_W-1:0]   acc;
        logic [VAL_W-1:0]   val0;
        logic [VAL_W-1:0]   val1;
        logic [VAL_W-1:0]   val2;
        logic [CNT_W-1:0]   bytes_seen;
    } t_state;

    // result word; last member sits in the lowest bits
    typedef struct packed {
        logic [VAL_W-1:0] y_hot;
        logic [VAL_W-1:0] x_hot;
        logic             hot_ok;
        logic [VAL_W-1:0] height;
        logic [VAL_W-1:0] width;
        logic             size_ok;
    } t_result;

    // characters of the "#define" keyword by position
    function automatic logic [7:0] kw_char(input logic [KPOS_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h23; // '#'
            3'd1:    c = 8'h64; // 'd'
            3'd2:    c = 8'h65; // 'e'
            3'd3:    c = 8'h66; // 'f'
            3'd4:    c = 8'h69; // 'i'
            3'd5:    c = 8'h6E; // 'n'
            3'd6:    c = 8'h65; // 'e'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/xbm_hp_step.sv =====
`default_nettype none
// ============================================================================
// xbm_hp_step
// Next-state and result logic for one header byte.
// ============================================================================
module xbm_hp_step (
    input  wire xbm_hp_pkg::t_state  i_state,
    input  wire logic [7:0]          i_byte,
    input  wire logic                i_last,
    output xbm_hp_pkg::t_state       o_state,
    output xbm_hp_pkg::t_result      o_result
);
    import xbm_hp_pkg::*;

    localparam logic [PHASE_W-1:0] PH_KEYWORD = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SPACE1  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_NAME    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SPACE2  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DIGITS  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_EOL     = 3'd5;

    localparam logic [KPOS_W-1:0]  KW_LAST    = 3'd6;

    logic             is_blank;
    logic             is_digit;
    logic             is_eol;
    logic [3:0]       digit;
    logic [VAL_W+3:0] acc_x10;
    logic [VAL_W-1:0] acc_next;
    t_state           s;
    logic             size_ok;
    logic             hot_ok;

    assign is_blank = (i_byte == 8'h20) || (i_byte == 8'h09);
    assign is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign is_eol   = (i_byte == 8'h0A) || (i_byte == 8'h0D);
    assign digit    = 4'(i_byte - 8'h30);

    // acc*10 + digit, saturating
    assign acc_x10  = ({4'b0, i_state.acc} << 3) + ({4'b0, i_state.acc} << 1)
                    + {31'b0, digit};
    assign acc_next = (acc_x10 > {4'b0, VAL_MAX}) ? VAL_MAX : acc_x10[VAL_W-1:0];

    always_comb begin
        logic             kw_run;
        logic [KPOS_W-1:0] kw_pos;
        s      = i_state;
        kw_run = 1'b0;
        kw_pos = i_state.kw_pos;

        if (i_state.bytes_seen < MIN_BYTES) begin
            s.bytes_seen = i_state.bytes_seen + 1'b1;
        end

        if (!i_state.failed && i_state.lines_done < 3'd4) begin
            unique case (i_state.phase)
                PH_KEYWORD: begin
                    kw_run = 1'b1;
                end
                PH_SPACE1: begin
                    if (!is_blank) s.phase = PH_NAME;
                end
                PH_NAME: begin
                    if (is_blank) s.phase = PH_SPACE2;
                end
                PH_SPACE2: begin
                    if (is_digit) begin
                        s.acc   = {27'b0, digit};
                        s.phase = PH_DIGITS;
                    end else if (!is_blank) begin
                        s.failed = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        s.acc = acc_next;
                    end else begin
                        case (i_state.lines_done)
                            3'd0:    s.val0 = i_state.acc;
                            3'd1:    s.val1 = i_state.acc;
                            3'd2:    s.val2 = i_state.acc;
                            default: ;
                        endcase
                        s.lines_done = i_state.lines_done + 1'b1;
                        if (i_state.lines_done != 3'd3) begin
                            if (is_eol) begin
                                s.phase = PH_EOL;
                            end else begin
                                kw_run = 1'b1;
                                kw_pos = '0;
                            end
                        end
                    end
                end
                PH_EOL: begin
                    if (!is_eol) begin
                        kw_run = 1'b1;
                        kw_pos = '0;
                    end
                end
                default: begin
                    s.failed = 1'b1;
                end
            endcase
        end

        // keyword match, shared by the keyword phase and line starts
        if (kw_run) begin
            s.phase = PH_KEYWORD;
            if (kw_pos == 3'd7 || i_byte != kw_char(kw_pos)) begin
                s.failed = 1'b1;
                s.kw_pos = kw_pos;
            end else if (kw_pos == KW_LAST) begin
                s.phase  = PH_SPACE1;
                s.kw_pos = '0;
            end else begin
                s.kw_pos = kw_pos + 1'b1;
            end
        end

        size_ok = (s.lines_done >= 3'd2) && (s.bytes_seen >= MIN_BYTES);
        hot_ok  = size_ok && (s.lines_done >= 3'd4);

        o_result.size_ok = size_ok;
        o_result.width   = size_ok ? s.val0 : '0;
        o_result.height  = size_ok ? s.val1 : '0;
        o_result.hot_ok  = hot_ok;
        o_result.x_hot   = hot_ok ? s.val2 : '0;
        o_result.y_hot   = hot_ok ? s.acc  : '0;

        // final byte closes the header: back to reset state
        if (i_last) begin
            o_state            = '0;
            o_state.phase      = PH_KEYWORD;
        end else begin
            o_state = s;
        end
    end

endmodule
`default_nettype wire

// ===== src/xbm_header_parser_core.sv =====
`default_nettype none
// ============================================================================
// xbm_header_parser_core
// Streaming XBM header parser: bytes in, one size/hot-spot word per header.
// ============================================================================
// Takes one header byte per word on the slave side, tlast on the final byte,
// and accepts a byte every cycle. Up to four "#define <name> <digits>" lines
// are parsed; values saturate at 2^31-1. For each header one result word
// leaves on the master side, registered after its final byte is taken. A
// two-entry output buffer (result register plus skid) keeps the input
// running while a result waits; the input stalls only when both entries
// are full. Width/height are zero unless the first two lines parsed and
// at least 16 bytes came; the hot spot is zero unless all four parsed.
module xbm_header_parser_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave side
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [7:0]   i_s_tdata,   // [7:0] byte_in
    input  wire logic         i_s_tlast,   // last_byte
    // master side
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [127:0]      o_m_tdata    // [0] size_ok, [31:1] width,
                                           // [62:32] height, [63] hot_ok,
                                           // [94:64] x_hot, [125:95] y_hot
);
    import xbm_hp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result step_result;

    t_result r_main;
    logic    r_main_valid;
    t_result r_skid;
    logic    r_skid_valid;

    logic    s_accept;
    logic    push;
    logic    take;

    // parse logic for the current byte
    xbm_hp_step u_step (
        .i_state  (r_state),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_state  (n_state),
        .o_result (step_result)
    );

    assign o_s_tready = !r_skid_valid;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign push       = s_accept && i_s_tlast;
    assign take       = r_main_valid && i_m_tready;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s_accept) begin
            r_state <= n_state;
        end
    end

    // output buffer: main register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_main_valid || take) begin
                if (r_skid_valid) begin
                    r_main_valid <= 1'b1;
                    r_skid_valid <= push;
                end else begin
                    r_main_valid <= push;
                end
            end else if (push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || take) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
                if (push) r_skid <= step_result;
            end else if (push) begin
                r_main <= step_result;
            end
        end else if (push) begin
            r_skid <= step_result;
        end
    end

    assign o_m_tvalid = r_main_valid;
    assign o_m_tdata  = {2'b00, r_main};

endmodule
`default_nettype wire
